// ===== hdl/lcs_pkg.sv =====
// Shared package for the longest common substring block.
// Holds request codes, field widths, the controller state type and the
// command and status structs between the controller and the datapath.
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CODE_W  = 21;
  localparam int unsigned START_W = 6;
  localparam int unsigned LEN_W   = 7;

  localparam logic [REQ_W-1:0] REQ_FIRST  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SECOND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FINISH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROWLOAD,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } lcs_state_e;

  typedef struct packed {
    logic app_first;
    logic app_second;
    logic start;
    logic row_fetch;
    logic step;
    logic next_row;
    logic emit;
  } lcs_cmd_t;

  typedef struct packed {
    logic empty;
    logic j_last;
    logic i_last;
    logic out_free;
  } lcs_sts_t;

endpackage

// ===== hdl/longest_common_substring.sv =====
// Top level of the longest common substring block.
// Joins the lcs_ctrl state machine and the lcs_dp datapath; uses lcs_pkg.
//
//   Channel  Handshake               Fields
//   input    in_valid_i / in_stall_o req_type_i, char_code_i
//   output   out_valid_o/ out_stall_i match_start_o, match_len_o,
//                                    in_second_o, overflow_o
//
// Append requests are taken one per cycle.
// A finish request walks the kept DP row memory row by row, one inner
// character per cycle.
// Reset clears the counts, flags and result valid; the buffers need no clearing.
// Input stalls during a compute; output stalls hold the result register and
// delay only the next finish, not the appends.
`timescale 1ns / 1ps

module longest_common_substring #(
  parameter int unsigned MAX_CHARS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lcs_pkg::REQ_W-1:0]      req_type_i,
  input  logic [lcs_pkg::CODE_W-1:0]     char_code_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lcs_pkg::START_W-1:0]    match_start_o,
  output logic [lcs_pkg::LEN_W-1:0]      match_len_o,
  output logic                           in_second_o,
  output logic                           overflow_o
);
  import lcs_pkg::*;

  lcs_cmd_t cmd;
  lcs_sts_t sts;

  lcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcs_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_code_i   (char_code_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .match_start_o (match_start_o),
    .match_len_o   (match_len_o),
    .in_second_o   (in_second_o),
    .overflow_o    (overflow_o)
  );

endmodule

// ===== hdl/lcs_ctrl.sv =====
// Controller state machine for the longest common substring block.
// Sequences loading, the row walk and result hand-off; uses lcs_pkg.
`timescale 1ns / 1ps

module lcs_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lcs_pkg::REQ_W-1:0]    req_type_i,
  input  lcs_pkg::lcs_sts_t            sts_i,
  output lcs_pkg::lcs_cmd_t            cmd_o
);
  import lcs_pkg::*;

  lcs_state_e state_q, state_d;
  logic       in_accept;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (req_type_i == REQ_FINISH)) begin
          state_d = sts_i.empty ? ST_RESULT : ST_ROWLOAD;
        end
      end
      ST_ROWLOAD: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.j_last) begin
          state_d = sts_i.i_last ? ST_DRAIN : ST_ROWLOAD;
        end
      end
      ST_DRAIN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.app_first  = in_accept && (req_type_i == REQ_FIRST);
        cmd_o.app_second = in_accept && (req_type_i == REQ_SECOND);
        cmd_o.start      = in_accept && (req_type_i == REQ_FINISH);
      end
      ST_ROWLOAD: begin
        cmd_o.row_fetch = 1'b1;
      end
      ST_WALK: begin
        cmd_o.step     = 1'b1;
        cmd_o.next_row = sts_i.j_last && !sts_i.i_last;
      end
      ST_RESULT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== hdl/lcs_dp.sv =====
// Datapath for the longest common substring block: string buffers, the
// kept DP row, loop counters, best-match tracking and the result register.
// Driven by lcs_ctrl through the command and status structs of lcs_pkg.
`timescale 1ns / 1ps

module lcs_dp #(
  parameter int unsigned MAX_CHARS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [lcs_pkg::CODE_W-1:0]     char_code_i,
  input  lcs_pkg::lcs_cmd_t              cmd_i,
  output lcs_pkg::lcs_sts_t              sts_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [lcs_pkg::START_W-1:0]    match_start_o,
  output logic [lcs_pkg::LEN_W-1:0]      match_len_o,
  output logic                           in_second_o,
  output logic                           overflow_o
);
  import lcs_pkg::*;

  localparam int unsigned AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int unsigned CW = $clog2(MAX_CHARS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHARS);
  localparam logic [CW-1:0] ONE     = CW'(1);

  logic [CODE_W-1:0] first_mem  [MAX_CHARS];
  logic [CODE_W-1:0] second_mem [MAX_CHARS];
  logic [CW-1:0]     row_mem    [MAX_CHARS+1];

  logic [CODE_W-1:0] first_rdata_q, second_rdata_q;
  logic [CW-1:0]     row_rdata_q;

  logic [CW-1:0] first_count_q, first_count_d;
  logic [CW-1:0] second_count_q, second_count_d;
  logic          dropped_q, dropped_d;
  logic          second_outer_q, second_outer_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] best_len_q, best_len_d;
  logic [CW-1:0] best_start_q, best_start_d;
  logic          b_valid_q, b_zero_q;
  logic [CW-1:0] b_j_q, b_i_q;
  logic          out_valid_q, out_valid_d;
  logic [START_W-1:0] match_start_q;
  logic [LEN_W-1:0]   match_len_q;
  logic               in_second_q, overflow_q;

  logic [CW-1:0]     n_outer, n_inner, im1, jm1, prev_run, run_v;
  logic [AW-1:0]     first_raddr, second_raddr;
  logic              first_we, second_we, first_re, second_re, hit;
  logic [CODE_W-1:0] outer_char, inner_char;

  assign n_outer = second_outer_q ? second_count_q : first_count_q;
  assign n_inner = second_outer_q ? first_count_q : second_count_q;
  assign im1     = i_q - ONE;
  assign jm1     = j_q - ONE;

  assign first_we  = cmd_i.app_first && (first_count_q < MAX_CNT);
  assign second_we = cmd_i.app_second && (second_count_q < MAX_CNT);
  assign first_re  = second_outer_q ? cmd_i.step : cmd_i.row_fetch;
  assign second_re = second_outer_q ? cmd_i.row_fetch : cmd_i.step;
  assign first_raddr  = second_outer_q ? jm1[AW-1:0] : im1[AW-1:0];
  assign second_raddr = second_outer_q ? im1[AW-1:0] : jm1[AW-1:0];

  assign outer_char = second_outer_q ? second_rdata_q : first_rdata_q;
  assign inner_char = second_outer_q ? first_rdata_q : second_rdata_q;
  assign hit        = (outer_char == inner_char);
  assign prev_run   = b_zero_q ? '0 : row_rdata_q;
  assign run_v      = prev_run + ONE;

  always_ff @(posedge clk_i) begin
    if (first_we) begin
      first_mem[first_count_q[AW-1:0]] <= char_code_i;
    end
    if (first_re) begin
      first_rdata_q <= first_mem[first_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (second_we) begin
      second_mem[second_count_q[AW-1:0]] <= char_code_i;
    end
    if (second_re) begin
      second_rdata_q <= second_mem[second_raddr];
    end
  end

  // The previous row's entry is read in the cycle before the compare.
  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      row_mem[b_j_q] <= hit ? run_v : '0;
    end
    if (cmd_i.step) begin
      row_rdata_q <= row_mem[jm1];
    end
  end

  always_comb begin
    first_count_d  = first_count_q;
    second_count_d = second_count_q;
    dropped_d      = dropped_q;
    second_outer_d = second_outer_q;
    i_d            = i_q;
    j_d            = j_q;
    best_len_d     = best_len_q;
    best_start_d   = best_start_q;
    out_valid_d    = out_valid_q && out_stall_i;
    if (cmd_i.app_first) begin
      if (first_we) begin
        first_count_d = first_count_q + ONE;
      end else begin
        dropped_d = 1'b1;
      end
    end
    if (cmd_i.app_second) begin
      if (second_we) begin
        second_count_d = second_count_q + ONE;
      end else begin
        dropped_d = 1'b1;
      end
    end
    if (cmd_i.start) begin
      second_outer_d = first_count_q > second_count_q;
      i_d            = ONE;
      best_len_d     = '0;
      best_start_d   = '0;
    end
    if (cmd_i.row_fetch) begin
      j_d = n_inner;
    end
    if (cmd_i.step) begin
      j_d = jm1;
    end
    if (cmd_i.next_row) begin
      i_d = i_q + ONE;
    end
    if (b_valid_q && hit && (run_v > best_len_q)) begin
      best_len_d   = run_v;
      best_start_d = b_i_q - run_v;
    end
    if (cmd_i.emit) begin
      first_count_d  = '0;
      second_count_d = '0;
      dropped_d      = 1'b0;
      out_valid_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_count_q  <= '0;
      second_count_q <= '0;
      dropped_q      <= 1'b0;
      second_outer_q <= 1'b0;
      i_q            <= '0;
      j_q            <= '0;
      best_len_q     <= '0;
      best_start_q   <= '0;
      b_valid_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      first_count_q  <= first_count_d;
      second_count_q <= second_count_d;
      dropped_q      <= dropped_d;
      second_outer_q <= second_outer_d;
      i_q            <= i_d;
      j_q            <= j_d;
      best_len_q     <= best_len_d;
      best_start_q   <= best_start_d;
      b_valid_q      <= cmd_i.step;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      b_j_q    <= j_q;
      b_i_q    <= i_q;
      b_zero_q <= (i_q == ONE) || (j_q == ONE);
    end
    if (cmd_i.emit) begin
      match_start_q <= START_W'(best_start_q);
      match_len_q   <= LEN_W'(best_len_q);
      in_second_q   <= second_outer_q;
      overflow_q    <= dropped_q;
    end
  end

  assign sts_o.empty    = (first_count_q == '0) || (second_count_q == '0);
  assign sts_o.j_last   = (j_q == ONE);
  assign sts_o.i_last   = (i_q == n_outer);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign match_start_o = match_start_q;
  assign match_len_o   = match_len_q;
  assign in_second_o   = in_second_q;
  assign overflow_o    = overflow_q;

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (j_q != '0) && (j_q <= n_inner) && (i_q <= n_outer))
    else $error("DP step issued outside the string bounds.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_count_q <= MAX_CNT) && (second_count_q <= MAX_CNT))
    else $error("Character count exceeds the buffer size.");

  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (best_len_q <= first_count_q) && (best_len_q <= second_count_q))
    else $error("Match length exceeds a string length.");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("Result register loaded while a result is still held.");

endmodule
